FILE: hw/rtl/cmbs_pkg.sv
// ----------------------------------------------------------------------------
// Cube-map sampler package
// Shared constants, codes, types and helpers of the cube-map sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cmbs_pkg;

  localparam int unsigned FaceSize   = 64;
  localparam int unsigned FaceBits   = 6;
  localparam int unsigned NumFaces   = 6;
  localparam int unsigned StoreDepth = NumFaces * FaceSize * FaceSize;
  localparam int unsigned AddrBits   = 15;
  localparam int unsigned ExtBits    = 7;
  localparam int unsigned TexelBits  = 48;
  localparam int unsigned AccBits    = 48;

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_SAMPLE = 1'b1;
  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVU,
    ST_DIVV,
    ST_POSX,
    ST_POSY,
    ST_POSW,
    ST_READ,
    ST_BLEND,
    ST_ROUND,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        clr;
    logic [31:0] a;
    logic [16:0] b;
  } mac_op_t;

  function automatic logic [ExtBits-1:0] clamp_ext(input logic [ExtBits-1:0] n);
    logic [ExtBits-1:0] r;
    r = n;
    if (n == '0) begin
      r = ExtBits'(1);
    end else if (n > ExtBits'(FaceSize)) begin
      r = ExtBits'(FaceSize);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cmbs_div.sv
// ----------------------------------------------------------------------------
// Coordinate divider
// Restoring divider that forms num * 2^15 / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmbs_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [16:0]       quo_o
);
  import cmbs_pkg::*;

  logic [15:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [16:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    trial  = {rem_q, num_q[31]};
    ge     = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      num_d = {req_i.num, 15'd0};
      quo_d = '0;
      den_d = req_i.den;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[15:0] : trial[15:0];
      num_d = {num_q[30:0], 1'b0};
      quo_d = {quo_q[15:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cmbs_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Shared 32 x 17 multiplier with a 48-bit accumulator for positions and blends.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbs_mac (
  input  logic             clk_i,
  input  cmbs_pkg::mac_op_t op_i,
  output logic [47:0]      acc_o
);
  import cmbs_pkg::*;

  logic [48:0]        prod;
  logic [AccBits-1:0] acc_q;

  assign prod = op_i.a * op_i.b;

  always_ff @(posedge clk_i) begin
    acc_q <= (op_i.clr ? '0 : acc_q) + prod[AccBits-1:0];
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cmbs_store.sv
// ----------------------------------------------------------------------------
// Texel store
// Six-face RGB texel memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbs_store (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [14:0] waddr_i,
  input  logic [47:0] wdata_i,
  input  logic [14:0] raddr_i,
  output logic [47:0] rdata_o
);
  import cmbs_pkg::*;

  logic [TexelBits-1:0] mem_q [StoreDepth];
  logic [TexelBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cube_map_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Cube-map bilinear sampler
// Stores RGB texels of six faces and returns bilinear samples along directions.
// ----------------------------------------------------------------------------
// A texel write is taken and busy stays low. A sample runs through the two
// 32-step divisions of the shared divider, then four reads from the single
// store read port and 18 steps of the shared multiply-accumulate unit; a zero
// direction skips the divisions. The result is valid on the outputs in the
// cycle in which done_o is high, and the receiver cannot hold it off. The
// texel store has no reset.
`default_nettype none

module cube_map_bilinear_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        command_i,
  input  logic [2:0]  face_sel_i,
  input  logic [5:0]  texel_x_i,
  input  logic [5:0]  texel_y_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  output logic        done_o,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o,
  output logic [2:0]  face_o,
  output logic [15:0] u_coord_o,
  output logic [15:0] v_coord_o
);
  import cmbs_pkg::*;

  state_e state_q, state_d;
  logic [ExtBits-1:0] w_q, h_q;
  logic [2:0] rd_q, rd_d;
  logic [1:0] ch_q, ch_d;
  logic [2:0] sub_q, sub_d;

  logic [15:0] dx_q, dy_q, dz_q;
  logic [2:0]  face_q;
  logic [16:0] sv_q;
  logic [15:0] m_q;
  logic [15:0] uc_q, vc_q;
  logic [21:0] px_q, py_q;
  logic [TexelBits-1:0] tex_q [4];
  logic [31:0] top_q, bot_q;
  logic [15:0] red_q, green_q, blue_q;

  logic [15:0] ax, ay, az;
  logic [16:0] ex, ey, ez, nx, ny, nz;
  logic [2:0]  face_c;
  logic [16:0] su_c, sv_c;
  logic [15:0] m_c;
  logic        zero_c;

  div_req_t    div_req;
  logic        div_done;
  logic [16:0] div_quo;
  logic [15:0] quo_sat;
  mac_op_t     mac_op;
  logic [47:0] acc;
  logic [47:0] rsum;

  logic        accept, store_we;
  logic [AddrBits-1:0] raddr;
  logic [TexelBits-1:0] rdata;
  logic [ExtBits-1:0] w_ext, h_ext, wm1, hm1, x0p, y0p;
  logic [FaceBits-1:0] x0, x1, y0, y1, rx, ry;
  logic [15:0] fx, fy, c00, c10, c01, c11;
  logic [16:0] wx0, wy0;

  assign accept   = start && !busy;
  assign store_we = accept && (command_i == CMD_WRITE) && (face_sel_i <= FACE_NZ);
  assign busy     = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_RESP);

  // Face selection with x winning ties over y and y over z.
  always_comb begin
    ax = dx_q[15] ? 16'(~dx_q + 16'd1) : dx_q;
    ay = dy_q[15] ? 16'(~dy_q + 16'd1) : dy_q;
    az = dz_q[15] ? 16'(~dz_q + 16'd1) : dz_q;
    ex = {dx_q[15], dx_q};
    ey = {dy_q[15], dy_q};
    ez = {dz_q[15], dz_q};
    nx = 17'(~ex + 17'd1);
    ny = 17'(~ey + 17'd1);
    nz = 17'(~ez + 17'd1);
    zero_c = (ax == '0) && (ay == '0) && (az == '0);
    if (zero_c) begin
      face_c = FACE_PX;
      su_c   = '0;
      sv_c   = '0;
      m_c    = '0;
    end else if (ax >= ay && ax >= az) begin
      face_c = dx_q[15] ? FACE_NX : FACE_PX;
      su_c   = dx_q[15] ? ez : nz;
      sv_c   = ny;
      m_c    = ax;
    end else if (ay >= az) begin
      face_c = dy_q[15] ? FACE_NY : FACE_PY;
      su_c   = ex;
      sv_c   = dy_q[15] ? nz : ez;
      m_c    = ay;
    end else begin
      face_c = dz_q[15] ? FACE_NZ : FACE_PZ;
      su_c   = dz_q[15] ? nx : ex;
      sv_c   = ny;
      m_c    = az;
    end
  end

  assign quo_sat = div_quo[16] ? 16'hFFFF : div_quo[15:0];

  always_comb begin
    w_ext = clamp_ext(w_q);
    h_ext = clamp_ext(h_q);
    wm1   = w_ext - 7'd1;
    hm1   = h_ext - 7'd1;
    x0    = px_q[21:16];
    y0    = py_q[21:16];
    x0p   = {1'b0, x0} + 7'd1;
    y0p   = {1'b0, y0} + 7'd1;
    x1    = (x0p < w_ext) ? x0p[5:0] : wm1[5:0];
    y1    = (y0p < h_ext) ? y0p[5:0] : hm1[5:0];
    fx    = px_q[15:0];
    fy    = py_q[15:0];
    wx0   = 17'h10000 - {1'b0, fx};
    wy0   = 17'h10000 - {1'b0, fy};
    rx    = rd_q[0] ? x1 : x0;
    ry    = rd_q[1] ? y1 : y0;
    raddr = {face_q, ry, rx};
    c00   = tex_q[0][{ch_q, 4'd0} +: 16];
    c10   = tex_q[1][{ch_q, 4'd0} +: 16];
    c01   = tex_q[2][{ch_q, 4'd0} +: 16];
    c11   = tex_q[3][{ch_q, 4'd0} +: 16];
    rsum  = acc + 48'h0000_8000_0000;
  end

  always_comb begin
    state_d = state_q;
    rd_d    = rd_q;
    ch_d    = ch_q;
    sub_d   = sub_q;
    div_req = '{start: 1'b0, num: su_c + {1'b0, m_c}, den: m_c};
    mac_op  = '{clr: 1'b1, a: '0, b: '0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && command_i == CMD_SAMPLE) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        div_req.start = !zero_c;
        state_d = zero_c ? ST_POSX : ST_DIVU;
      end
      ST_DIVU: begin
        div_req.num = sv_q + {1'b0, m_q};
        div_req.den = m_q;
        if (div_done) begin
          div_req.start = 1'b1;
          state_d = ST_DIVV;
        end
      end
      ST_DIVV: begin
        if (div_done) begin
          state_d = ST_POSX;
        end
      end
      ST_POSX: begin
        mac_op  = '{clr: 1'b1, a: {16'd0, uc_q}, b: {10'd0, wm1}};
        state_d = ST_POSY;
      end
      ST_POSY: begin
        mac_op  = '{clr: 1'b1, a: {16'd0, vc_q}, b: {10'd0, hm1}};
        state_d = ST_POSW;
      end
      ST_POSW: begin
        rd_d    = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        rd_d = rd_q + 3'd1;
        if (rd_q == 3'd4) begin
          ch_d    = '0;
          sub_d   = '0;
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        case (sub_q)
          3'd0: mac_op = '{clr: 1'b1, a: {16'd0, c00}, b: wx0};
          3'd1: mac_op = '{clr: 1'b0, a: {16'd0, c10}, b: {1'b0, fx}};
          3'd2: mac_op = '{clr: 1'b1, a: {16'd0, c01}, b: wx0};
          3'd3: mac_op = '{clr: 1'b0, a: {16'd0, c11}, b: {1'b0, fx}};
          3'd4: mac_op = '{clr: 1'b1, a: top_q, b: wy0};
          default: mac_op = '{clr: 1'b0, a: bot_q, b: {1'b0, fy}};
        endcase
        if (sub_q == 3'd5) begin
          sub_d = '0;
          if (ch_q == 2'd2) begin
            state_d = ST_ROUND;
          end else begin
            ch_d = ch_q + 2'd1;
          end
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end
      ST_ROUND: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      w_q     <= ExtBits'(FaceSize);
      h_q     <= ExtBits'(FaceSize);
      rd_q    <= '0;
      ch_q    <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      ch_q    <= ch_d;
      sub_q   <= sub_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          w_q <= cfg_data_i;
        end else begin
          h_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
      dz_q <= dir_z_i;
    end
    if (state_q == ST_SETUP) begin
      face_q <= face_c;
      sv_q   <= sv_c;
      m_q    <= m_c;
      uc_q   <= 16'h8000;
      vc_q   <= 16'h8000;
    end
    if (state_q == ST_DIVU && div_done) begin
      uc_q <= quo_sat;
    end
    if (state_q == ST_DIVV && div_done) begin
      vc_q <= quo_sat;
    end
    if (state_q == ST_POSY) begin
      px_q <= acc[21:0];
    end
    if (state_q == ST_POSW) begin
      py_q <= acc[21:0];
    end
    if (state_q == ST_READ && rd_q != 3'd0) begin
      tex_q[rd_q[1:0] - 2'd1] <= rdata;
    end
    if (state_q == ST_BLEND) begin
      if (sub_q == 3'd2) begin
        top_q <= acc[31:0];
      end
      if (sub_q == 3'd4) begin
        bot_q <= acc[31:0];
      end
      if (sub_q == 3'd0 && ch_q == 2'd1) begin
        red_q <= rsum[47:32];
      end
      if (sub_q == 3'd0 && ch_q == 2'd2) begin
        green_q <= rsum[47:32];
      end
    end
    if (state_q == ST_ROUND) begin
      blue_q <= rsum[47:32];
    end
  end

  cmbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  cmbs_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  cmbs_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i ({face_sel_i, texel_y_i, texel_x_i}),
    .wdata_i ({blue_in_i, green_in_i, red_in_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign red_o     = red_q;
  assign green_o   = green_q;
  assign blue_o    = blue_q;
  assign face_o    = face_q;
  assign u_coord_o = uc_q;
  assign v_coord_o = vc_q;

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_SAMPLE |=> busy)
    else $error("sample transfer did not make the block busy");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_WRITE |=> !busy)
    else $error("texel write made the block busy");

  a_done_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> face_o <= FACE_NZ)
    else $error("result carries an invalid face");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVU || state_q == ST_DIVV))
    else $error("divider finished outside a division state");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Cube-map bilinear sampler testbench
// Drives texel writes, direction samples and extent register settings into the
// sampler. A local model predicts every sample, and a monitor compares each
// result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import cmbs_pkg::*;

  typedef struct {
    logic        command;
    logic [2:0]  face_sel;
    logic [5:0]  texel_x;
    logic [5:0]  texel_y;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
  } cmd_item_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [2:0]  face;
    logic [15:0] u_coord;
    logic [15:0] v_coord;
  } sample_t;

  typedef struct {
    sample_t     res;
    int unsigned a00;
    int unsigned a10;
    int unsigned a01;
    int unsigned a11;
    int unsigned fx;
    int unsigned fy;
  } spot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_WIDTH;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [15:0] red_o, green_o, blue_o, u_o, v_o;
  logic [2:0]  face_o;
  cmd_item_t   cur_item = '{default: '0};

  cmd_item_t   pending_q[$];
  sample_t     sample_q[$];
  logic [47:0] texels[StoreDepth];
  bit          written[StoreDepth];
  int unsigned width_reg = 64;
  int unsigned height_reg = 64;
  int unsigned accepted = 0;
  int unsigned pushed = 0;
  int unsigned mismatches = 0;
  logic [6:0]  widths[8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd37, 7'd64};
  logic [6:0]  heights[8] = '{7'd64, 7'd0, 7'd1, 7'd2, 7'd127, 7'd100, 7'd23, 7'd64};

  always #1 clk_i = ~clk_i;

  cube_map_bilinear_sampler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .command_i  (cur_item.command),
    .face_sel_i (cur_item.face_sel),
    .texel_x_i  (cur_item.texel_x),
    .texel_y_i  (cur_item.texel_y),
    .red_in_i   (cur_item.red),
    .green_in_i (cur_item.green),
    .blue_in_i  (cur_item.blue),
    .dir_x_i    (cur_item.dir_x),
    .dir_y_i    (cur_item.dir_y),
    .dir_z_i    (cur_item.dir_z),
    .done_o     (done),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .face_o     (face_o),
    .u_coord_o  (u_o),
    .v_coord_o  (v_o)
  );

  function automatic int unsigned face_coord(input int s, input int m);
    longint q;
    q = (longint'(s + m) * 32768) / m;
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  function automatic int unsigned used_extent(input int unsigned n);
    if (n == 0) return 1;
    if (n > FaceSize) return FaceSize;
    return n;
  endfunction

  function automatic spot_t locate(input cmd_item_t it, input int unsigned wr,
                                   input int unsigned hr);
    int dx, dy, dz, ax, ay, az;
    int unsigned uc, vc, w, h, x0, x1, y0, y1, base;
    logic [2:0] fc;
    spot_t sp;
    dx = $signed(it.dir_x);
    dy = $signed(it.dir_y);
    dz = $signed(it.dir_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    if (ax == 0 && ay == 0 && az == 0) begin
      fc = FACE_PX;
      uc = 32768;
      vc = 32768;
    end else if (ax >= ay && ax >= az) begin
      fc = dx >= 0 ? FACE_PX : FACE_NX;
      uc = face_coord(dx >= 0 ? -dz : dz, ax);
      vc = face_coord(-dy, ax);
    end else if (ay >= az) begin
      fc = dy >= 0 ? FACE_PY : FACE_NY;
      uc = face_coord(dx, ay);
      vc = face_coord(dy >= 0 ? dz : -dz, ay);
    end else begin
      fc = dz >= 0 ? FACE_PZ : FACE_NZ;
      uc = face_coord(dz >= 0 ? dx : -dx, az);
      vc = face_coord(-dy, az);
    end
    w = used_extent(wr);
    h = used_extent(hr);
    x0 = (uc * (w - 1)) >> 16;
    sp.fx = (uc * (w - 1)) & 16'hFFFF;
    y0 = (vc * (h - 1)) >> 16;
    sp.fy = (vc * (h - 1)) & 16'hFFFF;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    base = fc * FaceSize * FaceSize;
    sp.a00 = base + y0 * FaceSize + x0;
    sp.a10 = base + y0 * FaceSize + x1;
    sp.a01 = base + y1 * FaceSize + x0;
    sp.a11 = base + y1 * FaceSize + x1;
    sp.res = '{default: '0};
    sp.res.face = fc;
    sp.res.u_coord = 16'(uc);
    sp.res.v_coord = 16'(vc);
    return sp;
  endfunction

  function automatic void apply_item(input cmd_item_t it);
    spot_t sp;
    logic [47:0] t00, t10, t01, t11;
    logic [63:0] top, bot, acc;
    logic [15:0] ch[3];
    sample_t res;
    if (it.command == CMD_WRITE) begin
      if (it.face_sel <= FACE_NZ)
        texels[(it.face_sel * FaceSize + it.texel_y) * FaceSize + it.texel_x] =
          {it.blue, it.green, it.red};
      return;
    end
    sp = locate(it, width_reg, height_reg);
    t00 = texels[sp.a00];
    t10 = texels[sp.a10];
    t01 = texels[sp.a01];
    t11 = texels[sp.a11];
    for (int k = 0; k < 3; k++) begin
      top = 64'(t00[16*k +: 16]) * (65536 - sp.fx) + 64'(t10[16*k +: 16]) * sp.fx;
      bot = 64'(t01[16*k +: 16]) * (65536 - sp.fx) + 64'(t11[16*k +: 16]) * sp.fx;
      acc = top * (65536 - sp.fy) + bot * sp.fy;
      ch[k] = 16'((acc + 64'h8000_0000) >> 32);
    end
    res = sp.res;
    res.red = ch[0];
    res.green = ch[1];
    res.blue = ch[2];
    sample_q.push_back(res);
  endfunction

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_item_t make_sample(input int kind);
    cmd_item_t it;
    logic [15:0] mag;
    it = '{default: '0};
    it.command = CMD_SAMPLE;
    it.face_sel = 3'($urandom);
    it.texel_x = 6'($urandom);
    it.texel_y = 6'($urandom);
    mag = 16'($urandom_range(1, 32767));
    case (kind)
      0: begin
        it.dir_x = 16'($urandom);
        it.dir_y = 16'($urandom);
        it.dir_z = 16'($urandom);
      end
      1: begin
        it.dir_x = $urandom_range(0, 1) ? mag : -mag;
        it.dir_y = $urandom_range(0, 1) ? mag : -mag;
        it.dir_z = $urandom_range(0, 1) ? mag : 16'($urandom_range(0, 32767));
      end
      2: begin
        it.dir_x = 16'($urandom_range(0, 32767));
        it.dir_y = $urandom_range(0, 1) ? mag : -mag;
        it.dir_z = $urandom_range(0, 1) ? mag : -mag;
      end
      default: begin
        it.dir_x = pick_component();
        it.dir_y = pick_component();
        it.dir_z = pick_component();
      end
    endcase
    return it;
  endfunction

  function automatic cmd_item_t make_write();
    cmd_item_t it;
    it = '{default: '0};
    it.command = CMD_WRITE;
    it.face_sel = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
    it.texel_x = 6'($urandom);
    it.texel_y = 6'($urandom);
    it.red = 16'($urandom);
    it.green = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    it.blue = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    it.dir_x = 16'($urandom);
    it.dir_y = 16'($urandom);
    it.dir_z = 16'($urandom);
    return it;
  endfunction

  function automatic void queue_item(input cmd_item_t it);
    if (it.command == CMD_WRITE && it.face_sel <= FACE_NZ)
      written[(it.face_sel * FaceSize + it.texel_y) * FaceSize + it.texel_x] = 1'b1;
    pending_q.push_back(it);
    pushed++;
  endfunction

  function automatic void cover_texel(input int unsigned a);
    cmd_item_t it;
    if (!written[a]) begin
      it = make_write();
      it.face_sel = 3'(a / (FaceSize * FaceSize));
      it.texel_y = 6'(a / FaceSize);
      it.texel_x = 6'(a);
      queue_item(it);
    end
  endfunction

  // Every texel that a sample reads is written ahead of it.
  function automatic void queue_sample(input cmd_item_t it);
    spot_t sp;
    sp = locate(it, width_reg, height_reg);
    cover_texel(sp.a00);
    cover_texel(sp.a10);
    cover_texel(sp.a01);
    cover_texel(sp.a11);
    queue_item(it);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        apply_item(cur_item);
        accepted <= accepted + 1;
      end
      if (pending_q.size() != 0 &&
          ((accepted >= 700 && accepted < 1000) || $urandom_range(0, 99) >= 31)) begin
        cur_item <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input sample_t exp_s, input sample_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %h %h %h face %0d uv %h %h, got %h %h %h face %0d uv %h %h",
               what, exp_s.red, exp_s.green, exp_s.blue, exp_s.face, exp_s.u_coord,
               exp_s.v_coord, got.red, got.green, got.blue, got.face, got.u_coord,
               got.v_coord);
  endtask

  always @(posedge clk_i) begin
    sample_t got, exp_s;
    if (rst_ni && done) begin
      got = '{red_o, green_o, blue_o, face_o, u_o, v_o};
      if (sample_q.size() == 0) begin
        exp_s = '{default: '0};
        report_mismatch("unexpected result", exp_s, got);
      end else begin
        exp_s = sample_q.pop_front();
        if (got.red !== exp_s.red || got.green !== exp_s.green ||
            got.blue !== exp_s.blue || got.face !== exp_s.face ||
            got.u_coord !== exp_s.u_coord || got.v_coord !== exp_s.v_coord)
          report_mismatch("sample mismatch", exp_s, got);
      end
    end
  end

  task automatic wait_quiet();
    while (pending_q.size() != 0 || start || sample_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_extent(input logic idx, input logic [6:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  initial begin
    cmd_item_t it;
    int unsigned goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    it = make_sample(3);
    it.dir_x = 16'h0000; it.dir_y = 16'h0000; it.dir_z = 16'h0000;
    queue_sample(it);
    for (int f = 0; f < 6; f++) begin
      it = make_sample(3);
      it.dir_x = 16'h0000; it.dir_y = 16'h0000; it.dir_z = 16'h0000;
      if (f / 2 == 0) it.dir_x = (f % 2) ? 16'h8000 : 16'h7FFF;
      if (f / 2 == 1) it.dir_y = (f % 2) ? 16'h8000 : 16'h7FFF;
      if (f / 2 == 2) it.dir_z = (f % 2) ? 16'h8000 : 16'h7FFF;
      queue_sample(it);
    end
    it = make_sample(3);
    it.dir_x = 16'h4000; it.dir_y = 16'hC000; it.dir_z = 16'h4000;
    queue_sample(it);
    it.dir_x = 16'h0100; it.dir_y = 16'h0100; it.dir_z = 16'hFF00;
    queue_sample(it);
    it.dir_x = 16'h8000; it.dir_y = 16'h7FFF; it.dir_z = 16'h8000;
    queue_sample(it);
    it.dir_x = 16'h0001; it.dir_y = 16'hFFFF; it.dir_z = 16'h0000;
    queue_sample(it);
    it = make_write();
    it.face_sel = 3'd7;
    queue_item(it);
    it = make_write();
    it.face_sel = 3'd6;
    queue_item(it);
    it = make_write();
    it.face_sel = FACE_NZ; it.texel_x = 6'd63; it.texel_y = 6'd63;
    it.red = 16'hFFFF; it.green = 16'h0000; it.blue = 16'hFFFF;
    queue_item(it);
    it = make_sample(3);
    it.dir_x = 16'h0000; it.dir_y = 16'h8000; it.dir_z = 16'h8000;
    queue_sample(it);

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      write_extent(CFG_WIDTH, widths[p]);
      write_extent(CFG_HEIGHT, heights[p]);
      goal = pushed + 236;
      while (pushed < goal) begin
        if ($urandom_range(0, 99) < 60) queue_sample(make_sample($urandom_range(0, 5)));
        else queue_item(make_write());
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/cmbs_pkg.sv
hw/rtl/cmbs_div.sv
hw/rtl/cmbs_mac.sv
hw/rtl/cmbs_store.sv
hw/rtl/cube_map_bilinear_sampler.sv
test/testbench.sv
